// ===== design/tiaf_pkg.sv =====
// Shared types and constants of the tagged identifier allocator.
package tiaf_pkg;

  localparam int ID_COUNT    = 1024;
  localparam int ID_BITS     = $clog2(ID_COUNT);
  localparam int NF_BITS     = ID_BITS + 1;
  localparam int TAG_BITS    = 2;
  localparam int FUNC_BITS   = 3;
  localparam int CNT_BITS    = 10;
  localparam int STAT_BITS   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [FUNC_BITS-1:0] FUNC_SPAWN   = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_DESTROY = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_QUERY   = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_CLEANUP = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_CLEAR   = 3'd4;

  localparam logic [STAT_BITS-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_IGNORED = 2'd2;

  typedef enum logic [2:0] {
    OP_SPAWN,
    OP_DESTROY,
    OP_QUERY,
    OP_CLEANUP,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [ID_BITS-1:0]   entity_id;
    logic [TAG_BITS-1:0]  lifespan_tag;
  } req_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   given_id;
    logic                 is_valid;
    logic [TAG_BITS-1:0]  tag_out;
    logic [CNT_BITS-1:0]  freed_count;
    logic [STAT_BITS-1:0] status;
  } rsp_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_BITS-1:0]  id;
    logic [TAG_BITS-1:0] tag;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_beat_t;

  typedef struct packed {
    logic                used;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

endpackage

// ===== design/tiaf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tiaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/tiaf_front.sv =====
// Front stage: accepts request beats and decodes them into commands.
module tiaf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  tiaf_pkg::req_t      cmd,
  output tiaf_pkg::cmd_beat_t push,
  input  logic                full
);

  logic            f_valid;
  tiaf_pkg::cmd_t  f_cmd;
  tiaf_pkg::cmd_t  dec;
  logic            accept;

  assign cmd_stall = f_valid && full;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    dec.id  = cmd.entity_id;
    dec.tag = cmd.lifespan_tag;
    unique case (cmd.func)
      tiaf_pkg::FUNC_SPAWN:   dec.op = tiaf_pkg::OP_SPAWN;
      tiaf_pkg::FUNC_DESTROY: dec.op = tiaf_pkg::OP_DESTROY;
      tiaf_pkg::FUNC_QUERY:   dec.op = tiaf_pkg::OP_QUERY;
      tiaf_pkg::FUNC_CLEANUP: dec.op = tiaf_pkg::OP_CLEANUP;
      tiaf_pkg::FUNC_CLEAR:   dec.op = tiaf_pkg::OP_CLEAR;
      default:                dec.op = tiaf_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (!full) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_cmd <= dec;
    end
  end

  assign push.valid = f_valid;
  assign push.cmd   = f_cmd;

endmodule

// ===== design/tiaf_queue.sv =====
// Short command queue between the front stage and the execution unit.
module tiaf_queue (
  input  logic                clk,
  input  logic                rst,
  input  tiaf_pkg::cmd_beat_t push,
  output logic                full,
  output tiaf_pkg::cmd_beat_t head,
  input  logic                pop
);

  tiaf_pkg::cmd_t                  slots [tiaf_pkg::QUEUE_DEPTH];
  logic [tiaf_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [tiaf_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [tiaf_pkg::QPTR_BITS:0]    count;
  logic                            do_push;
  logic                            do_pop;

  assign full       = count == (tiaf_pkg::QPTR_BITS+1)'(tiaf_pkg::QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.cmd   = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

endmodule

// ===== design/tiaf_back.sv =====
// Execution unit: identifier table, free stack, cleanup scan and result register.
module tiaf_back (
  input  logic                clk,
  input  logic                rst,
  input  tiaf_pkg::cmd_beat_t head,
  output logic                pop,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output tiaf_pkg::rsp_t      rsp
);

  localparam int IB = tiaf_pkg::ID_BITS;
  localparam int NB = tiaf_pkg::NF_BITS;
  localparam int EW = 1 + tiaf_pkg::TAG_BITS;
  localparam logic [NB-1:0] NF_LIMIT = NB'(tiaf_pkg::ID_COUNT);
  localparam logic [NB-1:0] NF_ONE   = NB'(1);
  localparam logic [NB-1:0] NF_TWO   = NB'(2);

  typedef enum logic [1:0] {S_IDLE, S_POP, S_CHECK, S_SCAN} state_t;

  state_t                         state, state_next;
  logic [NB-1:0]                  next_fresh, next_fresh_next;
  logic [NB-1:0]                  free_depth, free_depth_next;
  logic [NB-1:0]                  scan_addr, scan_addr_next;
  logic                           chk_valid, chk_valid_next;
  logic [IB-1:0]                  chk_id, chk_id_next;
  logic [tiaf_pkg::CNT_BITS-1:0]  freed, freed_next;
  tiaf_pkg::cmd_t                 cur, cur_next;
  tiaf_pkg::rsp_t                 res;
  logic                           load;

  logic                           st_we;
  logic [IB-1:0]                  st_waddr, st_raddr;
  tiaf_pkg::entry_t               st_wdata, st_rdata;
  logic                           sk_we;
  logic [IB-1:0]                  sk_waddr, sk_wdata, sk_raddr, sk_rdata;

  logic                           rsp_free;
  logic                           in_range;
  logic                           issue;
  logic [NB-1:0]                  fd_dec;

  tiaf_ram #(.WIDTH(EW), .DEPTH(tiaf_pkg::ID_COUNT)) u_table (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  tiaf_ram #(.WIDTH(IB), .DEPTH(tiaf_pkg::ID_COUNT)) u_stack (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  assign rsp_free = !rsp_valid || !rsp_stall;
  assign pop      = (state == S_IDLE) && head.valid && rsp_free;
  assign in_range = (head.cmd.id != '0) && ({1'b0, head.cmd.id} < next_fresh);
  assign issue    = scan_addr < next_fresh;
  assign fd_dec   = free_depth - NF_ONE;

  always_comb begin
    state_next      = state;
    next_fresh_next = next_fresh;
    free_depth_next = free_depth;
    scan_addr_next  = scan_addr;
    chk_valid_next  = 1'b0;
    chk_id_next     = chk_id;
    freed_next      = freed;
    cur_next        = cur;
    load            = 1'b0;
    res             = '0;
    st_we           = 1'b0;
    st_waddr        = head.cmd.id;
    st_wdata        = '0;
    st_raddr        = head.cmd.id;
    sk_we           = 1'b0;
    sk_waddr        = free_depth[IB-1:0];
    sk_wdata        = cur.id;
    sk_raddr        = fd_dec[IB-1:0];

    unique case (state)
      S_IDLE: begin
        if (pop) begin
          cur_next = head.cmd;
          unique case (head.cmd.op)
            tiaf_pkg::OP_SPAWN: begin
              if (free_depth != '0) begin
                free_depth_next = fd_dec;
                state_next      = S_POP;
              end else if (next_fresh < NF_LIMIT) begin
                st_we           = 1'b1;
                st_waddr        = next_fresh[IB-1:0];
                st_wdata        = '{used: 1'b1, tag: head.cmd.tag};
                next_fresh_next = next_fresh + NF_ONE;
                load            = 1'b1;
                res.given_id    = next_fresh[IB-1:0];
              end else begin
                load       = 1'b1;
                res.status = tiaf_pkg::ST_FULL;
              end
            end
            tiaf_pkg::OP_DESTROY: begin
              if (in_range) begin
                state_next = S_CHECK;
              end else begin
                load       = 1'b1;
                res.status = tiaf_pkg::ST_IGNORED;
              end
            end
            tiaf_pkg::OP_QUERY: begin
              if (in_range) begin
                state_next = S_CHECK;
              end else begin
                load = 1'b1;
              end
            end
            tiaf_pkg::OP_CLEANUP: begin
              if (next_fresh > NF_ONE) begin
                st_raddr       = NF_ONE[IB-1:0];
                scan_addr_next = NF_TWO;
                chk_valid_next = 1'b1;
                chk_id_next    = NF_ONE[IB-1:0];
                freed_next     = '0;
                state_next     = S_SCAN;
              end else begin
                load = 1'b1;
              end
            end
            tiaf_pkg::OP_CLEAR: begin
              next_fresh_next = NF_ONE;
              free_depth_next = '0;
              load            = 1'b1;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        st_we        = 1'b1;
        st_waddr     = sk_rdata;
        st_wdata     = '{used: 1'b1, tag: cur.tag};
        load         = 1'b1;
        res.given_id = sk_rdata;
        state_next   = S_IDLE;
      end
      S_CHECK: begin
        load       = 1'b1;
        state_next = S_IDLE;
        if (cur.op == tiaf_pkg::OP_QUERY) begin
          res.is_valid = st_rdata.used;
          res.tag_out  = st_rdata.used ? st_rdata.tag : '0;
        end else if (st_rdata.used) begin
          st_we    = 1'b1;
          st_waddr = cur.id;
          if (free_depth < NF_LIMIT) begin
            sk_we           = 1'b1;
            sk_wdata        = cur.id;
            free_depth_next = free_depth + NF_ONE;
          end
        end else begin
          res.status = tiaf_pkg::ST_IGNORED;
        end
      end
      S_SCAN: begin
        st_raddr = scan_addr[IB-1:0];
        if (chk_valid && st_rdata.used && (st_rdata.tag == cur.tag)) begin
          st_we      = 1'b1;
          st_waddr   = chk_id;
          freed_next = freed + 1'b1;
          if (free_depth < NF_LIMIT) begin
            sk_we           = 1'b1;
            sk_wdata        = chk_id;
            free_depth_next = free_depth + NF_ONE;
          end
        end
        chk_valid_next = issue;
        chk_id_next    = scan_addr[IB-1:0];
        if (issue) begin
          scan_addr_next = scan_addr + NF_ONE;
        end
        if (!chk_valid && !issue) begin
          load            = 1'b1;
          res.freed_count = freed;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_fresh <= NF_ONE;
      free_depth <= '0;
      chk_valid  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      next_fresh <= next_fresh_next;
      free_depth <= free_depth_next;
      chk_valid  <= chk_valid_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    scan_addr <= scan_addr_next;
    chk_id    <= chk_id_next;
    freed     <= freed_next;
    cur       <= cur_next;
    if (load) begin
      rsp <= res;
    end
  end

  a_fresh_range: assert property (@(posedge clk) disable iff (rst)
    next_fresh != '0 && next_fresh <= NF_LIMIT)
    else $error("fresh counter out of range");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    free_depth < next_fresh)
    else $error("free stack deeper than issued identifiers");

  a_busy_empty: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !rsp_valid)
    else $error("result register occupied while a command runs");

  a_push_release: assert property (@(posedge clk) disable iff (rst)
    sk_we |-> st_we && !st_wdata.used)
    else $error("stack push without releasing the identifier");

endmodule

// ===== design/tagged_id_allocator_free_stack.sv =====
// Top level of the tagged identifier allocator with a LIFO free stack.
// Identifiers run from 1 to 1023; a spawn reuses the most recently freed one or takes the
// next fresh one, and reports status 1 with identifier 0 once both are exhausted. Requests
// pass through a decode register and a two-beat command queue into one execution unit that
// runs a command at a time and leaves its result in an output register. Spawn from the fresh
// pool, clear, unknown functions and requests with an out-of-range identifier finish in
// the idle state; spawn from the free stack, destroy and query finish in S_POP or S_CHECK,
// after the registered read of the stack or identifier table. Cleanup reads every issued
// identifier through the single table read port. Clear is immediate: table entries at or
// above the fresh counter read as free, so no clearing pass runs after reset or clear.
module tagged_id_allocator_free_stack (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  tiaf_pkg::req_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output tiaf_pkg::rsp_t rsp
);

  tiaf_pkg::cmd_beat_t push;
  tiaf_pkg::cmd_beat_t head;
  logic                full;
  logic                pop;

  tiaf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .push      (push),
    .full      (full)
  );

  tiaf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  tiaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== tb/tiaf_id_checker.sv =====
// Checker for the tagged identifier allocator: predicts each response beat and compares it.
module tiaf_id_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  tiaf_pkg::req_t cmd,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  tiaf_pkg::rsp_t rsp,
  output int             mismatches,
  output int             owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_COUNT = tiaf_pkg::ID_COUNT;
  localparam int ID_BITS  = tiaf_pkg::ID_BITS;
  localparam int TAG_BITS = tiaf_pkg::TAG_BITS;
  localparam int CNT_BITS = tiaf_pkg::CNT_BITS;

  logic                in_use   [ID_COUNT];
  logic [TAG_BITS-1:0] id_tag   [ID_COUNT];
  logic [ID_BITS-1:0]  free_ids [ID_COUNT];
  int                  free_depth_m;
  int                  next_fresh_m;
  tiaf_pkg::rsp_t      owed_rsp [$];
  int                  errs = 0;

  function automatic void wipe_pool();
    for (int i = 0; i < ID_COUNT; i++) begin
      in_use[i] = 1'b0;
      id_tag[i] = '0;
      free_ids[i] = '0;
    end
    free_depth_m = 0;
    next_fresh_m = 1;
  endfunction

  function automatic bit id_live(logic [ID_BITS-1:0] id);
    return id != '0 && in_use[id];
  endfunction

  function automatic void free_id(int id);
    in_use[id] = 1'b0;
    id_tag[id] = '0;
    if (free_depth_m < ID_COUNT) begin
      free_ids[free_depth_m] = ID_BITS'(id);
      free_depth_m++;
    end
  endfunction

  function automatic tiaf_pkg::rsp_t allocator_result(tiaf_pkg::req_t r);
    tiaf_pkg::rsp_t res;
    int             id;
    int             cnt;
    res = '0;
    cnt = 0;
    id = 0;
    unique case (r.func)
      tiaf_pkg::FUNC_SPAWN: begin
        if (free_depth_m > 0) begin
          free_depth_m--;
          id = int'(free_ids[free_depth_m]);
        end else if (next_fresh_m < ID_COUNT) begin
          id = next_fresh_m;
          next_fresh_m++;
        end
        if (id == 0) begin
          res.status = tiaf_pkg::ST_FULL;
        end else begin
          in_use[id] = 1'b1;
          id_tag[id] = r.lifespan_tag;
          res.given_id = ID_BITS'(id);
        end
      end
      tiaf_pkg::FUNC_DESTROY: begin
        if (id_live(r.entity_id)) free_id(int'(r.entity_id));
        else res.status = tiaf_pkg::ST_IGNORED;
      end
      tiaf_pkg::FUNC_QUERY: begin
        if (id_live(r.entity_id)) begin
          res.is_valid = 1'b1;
          res.tag_out = id_tag[r.entity_id];
        end
      end
      tiaf_pkg::FUNC_CLEANUP: begin
        for (int i = 1; i < next_fresh_m && i < ID_COUNT; i++) begin
          if (in_use[i] && id_tag[i] == r.lifespan_tag) begin
            free_id(i);
            cnt++;
          end
        end
        res.freed_count = CNT_BITS'(cnt);
      end
      tiaf_pkg::FUNC_CLEAR: wipe_pool();
      default: ;
    endcase
    return res;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    tiaf_pkg::rsp_t want;
    if (rst) begin
      wipe_pool();
      owed_rsp.delete();
    end else begin
      if (cmd_valid && !cmd_stall) owed_rsp = {owed_rsp, allocator_result(cmd)};
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsp.size() == 0) begin
          $error("response beat with nothing outstanding");
          errs++;
        end else begin
          want = owed_rsp.pop_front();
          check_field("given_id", int'(want.given_id), int'(rsp.given_id));
          check_field("is_valid", int'(want.is_valid), int'(rsp.is_valid));
          check_field("tag_out", int'(want.tag_out), int'(rsp.tag_out));
          check_field("freed_count", int'(want.freed_count), int'(rsp.freed_count));
          check_field("status", int'(want.status), int'(rsp.status));
        end
      end
    end
    mismatches <= errs;
    owed <= owed_rsp.size();
  end

endmodule

// ===== tb/tagged_id_allocator_free_stack_test.sv =====
// Testbench top for the tagged identifier allocator: stimulus, stalls and verdict.
module tagged_id_allocator_free_stack_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_COUNT = tiaf_pkg::ID_COUNT;
  localparam int ID_BITS = tiaf_pkg::ID_BITS;
  localparam int TAG_BITS = tiaf_pkg::TAG_BITS;
  localparam int FUNC_BITS = tiaf_pkg::FUNC_BITS;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int RANDOM_BEATS = 540;
  localparam int BURST_SPAWNS = 40;
  localparam int HOT_IDS = 48;
  localparam int FUNC_CODES = 1 << FUNC_BITS;
  localparam int TAG_MAX = (1 << TAG_BITS) - 1;
  localparam logic [FUNC_BITS-1:0] FUNC_RSVD_FIRST = tiaf_pkg::FUNC_CLEAR + 1'b1;

  logic           clk = 1'b0;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_stall;
  tiaf_pkg::req_t cmd;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  tiaf_pkg::rsp_t rsp;
  int             mismatches;
  int             owed;
  int             cycle_count = 0;
  int             stall_left = 0;
  int             rx_phase_left = 0;
  bit             rx_calm = 1'b0;
  int             tx_left = 0;
  bit             tx_calm = 1'b0;

  tagged_id_allocator_free_stack u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  tiaf_id_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .mismatches (mismatches),
    .owed       (owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_calm <= ($urandom_range(0, 3) == 0);
      rx_phase_left <= $urandom_range(50, 300);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= 1'b1;
    end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
      rsp_stall <= 1'b1;
      stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  function automatic tiaf_pkg::req_t request(logic [FUNC_BITS-1:0] f, int id, int tag);
    tiaf_pkg::req_t r;
    r.func = f;
    r.entity_id = ID_BITS'(id);
    r.lifespan_tag = TAG_BITS'(tag);
    return r;
  endfunction

  function automatic int random_tag();
    return ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, TAG_MAX);
  endfunction

  function automatic int random_id();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 0;
    if (k == 1) return $urandom_range(0, ID_COUNT - 1);
    return $urandom_range(1, HOT_IDS);
  endfunction

  function automatic tiaf_pkg::req_t random_request();
    int w;
    logic [FUNC_BITS-1:0] f;
    w = $urandom_range(0, 99);
    if (w < 38) f = tiaf_pkg::FUNC_SPAWN;
    else if (w < 62) f = tiaf_pkg::FUNC_DESTROY;
    else if (w < 86) f = tiaf_pkg::FUNC_QUERY;
    else if (w < 91) f = tiaf_pkg::FUNC_CLEANUP;
    else if (w < 93) f = tiaf_pkg::FUNC_CLEAR;
    else if (w < 96) f = FUNC_BITS'($urandom_range(int'(FUNC_RSVD_FIRST), FUNC_CODES - 1));
    else f = tiaf_pkg::FUNC_SPAWN;
    return request(f, random_id(), random_tag());
  endfunction

  function automatic int beat_gap();
    int w;
    if (tx_left == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_left = $urandom_range(20, 120);
    end else begin
      tx_left--;
    end
    if (tx_calm) return 0;
    w = $urandom_range(0, 99);
    if (w < 55) return 0;
    if (w < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send(tiaf_pkg::req_t r);
    int gap;
    cmd <= r;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    gap = beat_gap();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every outstanding response has come back
  task automatic settle();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (owed != 0);
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(request(tiaf_pkg::FUNC_SPAWN, 0, 1));
    send(request(tiaf_pkg::FUNC_SPAWN, ID_COUNT - 1, 2));
    send(request(tiaf_pkg::FUNC_SPAWN, 0, 3));
    send(request(tiaf_pkg::FUNC_SPAWN, 0, 0));
    send(request(tiaf_pkg::FUNC_QUERY, 1, 0));
    send(request(tiaf_pkg::FUNC_QUERY, 4, 0));
    send(request(tiaf_pkg::FUNC_QUERY, 0, 0));
    send(request(tiaf_pkg::FUNC_QUERY, ID_COUNT - 1, TAG_MAX));
    send(request(tiaf_pkg::FUNC_DESTROY, 0, 0));
    send(request(tiaf_pkg::FUNC_DESTROY, ID_COUNT - 1, 0));
    send(request(tiaf_pkg::FUNC_DESTROY, 2, 0));
    send(request(tiaf_pkg::FUNC_DESTROY, 2, 0));
    send(request(tiaf_pkg::FUNC_SPAWN, 0, 3));
    send(request(tiaf_pkg::FUNC_CLEANUP, 0, 0));
    send(request(tiaf_pkg::FUNC_CLEANUP, 0, 3));
    send(request(tiaf_pkg::FUNC_SPAWN, 0, 1));
    send(request(tiaf_pkg::FUNC_QUERY, 3, 0));
    for (int f = int'(FUNC_RSVD_FIRST); f < FUNC_CODES; f++) begin
      send(request(FUNC_BITS'(f), ID_COUNT - 1, TAG_MAX));
    end
    send(request(tiaf_pkg::FUNC_CLEAR, 0, 0));
    send(request(tiaf_pkg::FUNC_QUERY, 1, 0));
    send(request(tiaf_pkg::FUNC_SPAWN, 0, 2));
    settle();

    // spawn a burst, then probe the top of the identifier range
    send(request(tiaf_pkg::FUNC_CLEAR, 0, 0));
    for (int i = 0; i < BURST_SPAWNS; i++) begin
      send(request(tiaf_pkg::FUNC_SPAWN, $urandom_range(0, ID_COUNT - 1), random_tag()));
    end
    send(request(tiaf_pkg::FUNC_QUERY, ID_COUNT - 1, 0));
    send(request(tiaf_pkg::FUNC_DESTROY, ID_COUNT - 1, 0));
    send(request(tiaf_pkg::FUNC_DESTROY, ID_COUNT - 1, 0));
    send(request(tiaf_pkg::FUNC_SPAWN, 0, 1));
    send(request(tiaf_pkg::FUNC_SPAWN, 0, 1));
    send(request(tiaf_pkg::FUNC_CLEANUP, 0, $urandom_range(0, TAG_MAX)));
    send(request(tiaf_pkg::FUNC_CLEANUP, 0, 2));
    send(request(tiaf_pkg::FUNC_QUERY, $urandom_range(1, ID_COUNT - 1), 0));
    send(request(tiaf_pkg::FUNC_SPAWN, 0, 3));
    settle();
    send(request(tiaf_pkg::FUNC_CLEAR, 0, 0));

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      send(random_request());
      if (i % 150 == 149) settle();
    end

    settle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
